@@ hdl/tple_pkg.sv @@
// ----------------------------------------------------------------------------
// tple_pkg
// Shared types, character codes and the microcode layout of the text page
// layout engine.
// ----------------------------------------------------------------------------
package tple_pkg;

    // character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_FF    = 8'h0C;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_SCREEN_COLUMNS = 2'd0;
    localparam logic [1:0] REG_SCREEN_LINES   = 2'd1;
    localparam logic [1:0] REG_TAB_WIDTH      = 2'd2;

    localparam logic [6:0] COLUMNS_RESET = 7'd40;
    localparam logic [5:0] LINES_RESET   = 6'd16;
    localparam logic [7:0] TAB_RESET     = 8'd4;
    localparam logic [4:0] TAB_DEFAULT   = 5'd4;
    localparam logic [4:0] TAB_MAX       = 5'd16;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_PUT_CHAR,
        OP_CLEAR_HOME,
        OP_BLANK_REST,
        OP_PAGE_END
    } op_kind_t;

    typedef enum logic [2:0] {
        CH_NONE,
        CH_BYTE,
        CH_CR,
        CH_LF,
        CH_BS,
        CH_SPACE
    } char_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_OPEN,   // last when the byte produces nothing after the page opens
        LAST_TAB     // last when this is the final pad space
    } last_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_OPEN,
        ACT_COUNT,
        ACT_CLOSE,
        ACT_WRAP,
        ACT_HOME,
        ACT_COL_DEC,
        ACT_COL_INC,
        ACT_MOD_STEP,
        ACT_SPC_INIT,
        ACT_TAB_PUT
    } action_t;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_ALWAYS,
        JMP_IF,
        JMP_IF_NOT,
        JMP_DISPATCH
    } jump_t;

    typedef enum logic [2:0] {
        CND_OPEN,
        CND_COL_OVF,
        CND_ROW_OVF,
        CND_COL_GT1,
        CND_BIT_ZERO,
        CND_SPC_ONE
    } cond_t;

    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_NUL,
        CLS_BS,
        CLS_FF,
        CLS_CR,
        CLS_TAB,
        CLS_LF
    } byte_class_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // program labels
    localparam upc_t L_FETCH = 5'd0;
    localparam upc_t L_CLEAR = 5'd1;
    localparam upc_t L_DISP  = 5'd2;
    localparam upc_t L_PRINT = 5'd3;
    localparam upc_t L_PUT   = 5'd8;
    localparam upc_t L_NUL   = 5'd9;
    localparam upc_t L_FULL  = 5'd10;
    localparam upc_t L_BS    = 5'd11;
    localparam upc_t L_FF    = 5'd15;
    localparam upc_t L_LF    = 5'd16;
    localparam upc_t L_TAB   = 5'd20;
    localparam upc_t L_TLOOP = 5'd22;
    localparam upc_t L_TPUT  = 5'd27;

    typedef struct packed {
        logic      wait_in;
        logic      emit;
        op_kind_t  op_kind;
        char_sel_t char_sel;
        last_sel_t last_sel;
        action_t   action;
        jump_t     jump;
        cond_t     cond;
        upc_t      target;
    } ctrl_word_t;

    typedef struct packed {
        logic        page_open;
        logic        col_ovf;
        logic        row_ovf;
        logic        col_gt1;
        logic        bit_zero;
        logic        spc_one;
        logic        out_busy;
        byte_class_t byte_class;
    } dp_status_t;

    function automatic upc_t dispatch_target(input byte_class_t cls);
        upc_t t;
        unique case (cls)
            CLS_NUL:  t = L_NUL;
            CLS_BS:   t = L_BS;
            CLS_FF:   t = L_FF;
            CLS_CR:   t = L_FETCH;
            CLS_TAB:  t = L_TAB;
            CLS_LF:   t = L_LF;
            default:  t = L_PRINT;
        endcase
        return t;
    endfunction

endpackage

@@ hdl/text_page_layout_engine.sv @@
// ----------------------------------------------------------------------------
// text_page_layout_engine
// Lays out the text bytes of one screen page and emits console operations.
// ----------------------------------------------------------------------------
// A microcoded sequencer steps through a 32-word control store, one step per
// clock unless a step holds, and takes one text word at a time. Each word
// passes the fetch and dispatch steps, and the first word of a page adds a
// clear step. A printable byte puts its character, after a line wrap when
// the line is full (or a page end when no row is left). A tab runs seven
// remainder steps of one column bit each, then the pad count, then a pad loop
// of one space per pass, with a wrap inside the pad when needed, and one
// closing step. The single output register lets the sequencer go on while a
// word waits there; an emit step holds only while that register is still
// occupied.
// ----------------------------------------------------------------------------
module text_page_layout_engine #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_LINES   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_op_kind,
    output logic [7:0]  m_out_char,
    output logic [5:0]  m_cursor_row,
    output logic [6:0]  m_cursor_col,
    output logic [15:0] m_bytes_used,
    output logic        m_last_of_run
);
    import tple_pkg::*;

    upc_t       upc;
    ctrl_word_t cw;
    dp_status_t status;
    logic       step_go;

    tple_ucode_rom u_rom (
        .upc (upc),
        .cw  (cw)
    );

    tple_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .cw      (cw),
        .status  (status),
        .upc     (upc),
        .step_go (step_go)
    );

    tple_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_text_byte   (s_text_byte),
        .cw            (cw),
        .step_go       (step_go),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_op_kind     (m_op_kind),
        .m_out_char    (m_out_char),
        .m_cursor_row  (m_cursor_row),
        .m_cursor_col  (m_cursor_col),
        .m_bytes_used  (m_bytes_used),
        .m_last_of_run (m_last_of_run),
        .status        (status)
    );

    // take a word only on the fetch step
    assign s_ready = cw.wait_in;

endmodule

@@ hdl/tple_ucode_rom.sv @@
// ----------------------------------------------------------------------------
// tple_ucode_rom
// Read-only control store: one control word per program step.
// ----------------------------------------------------------------------------
module tple_ucode_rom (
    input  tple_pkg::upc_t       upc,
    output tple_pkg::ctrl_word_t cw
);
    import tple_pkg::*;

    function automatic ctrl_word_t mk(
        input logic      wait_in,
        input logic      emit,
        input op_kind_t  op_kind,
        input char_sel_t char_sel,
        input last_sel_t last_sel,
        input action_t   action,
        input jump_t     jump,
        input cond_t     cond,
        input upc_t      target
    );
        ctrl_word_t w;
        w.wait_in  = wait_in;
        w.emit     = emit;
        w.op_kind  = op_kind;
        w.char_sel = char_sel;
        w.last_sel = last_sel;
        w.action   = action;
        w.jump     = jump;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    always_comb begin
        unique case (upc)
            // fetch a word; an open page skips the clear
            5'd0:  cw = mk(1'b1, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_LOAD,
                           JMP_IF, CND_OPEN, L_DISP);
            5'd1:  cw = mk(1'b0, 1'b1, OP_CLEAR_HOME, CH_NONE, LAST_OPEN, ACT_OPEN,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd2:  cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_COUNT,
                           JMP_DISPATCH, CND_OPEN, L_FETCH);
            // printable
            5'd3:  cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_IF_NOT, CND_COL_OVF, L_PUT);
            5'd4:  cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_WRAP,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd5:  cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_IF, CND_ROW_OVF, L_FULL);
            5'd6:  cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_CR, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd7:  cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_LF, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd8:  cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_BYTE, LAST_YES, ACT_COL_INC,
                           JMP_ALWAYS, CND_OPEN, L_FETCH);
            // page end by NUL, then shared page end
            5'd9:  cw = mk(1'b0, 1'b1, OP_BLANK_REST, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd10: cw = mk(1'b0, 1'b1, OP_PAGE_END, CH_NONE, LAST_YES, ACT_CLOSE,
                           JMP_ALWAYS, CND_OPEN, L_FETCH);
            // backspace: erase one column, never wrap up
            5'd11: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_IF_NOT, CND_COL_GT1, L_FETCH);
            5'd12: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_BS, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd13: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_SPACE, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd14: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_BS, LAST_YES, ACT_COL_DEC,
                           JMP_ALWAYS, CND_OPEN, L_FETCH);
            // form feed
            5'd15: cw = mk(1'b0, 1'b1, OP_CLEAR_HOME, CH_NONE, LAST_YES, ACT_HOME,
                           JMP_ALWAYS, CND_OPEN, L_FETCH);
            // newline
            5'd16: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_WRAP,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd17: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_IF, CND_ROW_OVF, L_FULL);
            5'd18: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_CR, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd19: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_LF, LAST_YES, ACT_NONE,
                           JMP_ALWAYS, CND_OPEN, L_FETCH);
            // tab: remainder one bit a step, then pad loop
            5'd20: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_MOD_STEP,
                           JMP_IF_NOT, CND_BIT_ZERO, L_TAB);
            5'd21: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_SPC_INIT,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd22: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_IF_NOT, CND_COL_OVF, L_TPUT);
            5'd23: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_WRAP,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd24: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                           JMP_IF, CND_ROW_OVF, L_FULL);
            5'd25: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_CR, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd26: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_LF, LAST_NO, ACT_NONE,
                           JMP_NONE, CND_OPEN, L_FETCH);
            5'd27: cw = mk(1'b0, 1'b1, OP_PUT_CHAR, CH_SPACE, LAST_TAB, ACT_TAB_PUT,
                           JMP_IF_NOT, CND_SPC_ONE, L_TLOOP);
            default: cw = mk(1'b0, 1'b0, OP_PUT_CHAR, CH_NONE, LAST_NO, ACT_NONE,
                             JMP_ALWAYS, CND_OPEN, L_FETCH);
        endcase
    end

endmodule

@@ hdl/tple_sequencer.sv @@
// ----------------------------------------------------------------------------
// tple_sequencer
// Step counter with conditional jumps and byte-class dispatch; holds the
// step while the input word is not there or the output register is still occupied.
// ----------------------------------------------------------------------------
module tple_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  tple_pkg::ctrl_word_t cw,
    input  tple_pkg::dp_status_t status,
    output tple_pkg::upc_t       upc,
    output logic                 step_go
);
    import tple_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_val;
    logic taken;

    always_comb begin
        unique case (cw.cond)
            CND_OPEN:     cond_val = status.page_open;
            CND_COL_OVF:  cond_val = status.col_ovf;
            CND_ROW_OVF:  cond_val = status.row_ovf;
            CND_COL_GT1:  cond_val = status.col_gt1;
            CND_BIT_ZERO: cond_val = status.bit_zero;
            CND_SPC_ONE:  cond_val = status.spc_one;
            default:      cond_val = 1'b0;
        endcase
    end

    assign step_go = !(cw.wait_in && !s_valid) && !(cw.emit && status.out_busy);

    always_comb begin
        unique case (cw.jump)
            JMP_ALWAYS, JMP_DISPATCH: taken = 1'b1;
            JMP_IF:                   taken = cond_val;
            JMP_IF_NOT:               taken = !cond_val;
            default:                  taken = 1'b0;
        endcase
    end

    always_comb begin
        upc_next = upc_reg;
        if (step_go) begin
            if (cw.jump == JMP_DISPATCH) begin
                upc_next = dispatch_target(status.byte_class);
            end else if (taken) begin
                upc_next = cw.target;
            end else begin
                upc_next = upc_reg + upc_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= L_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign upc = upc_reg;

endmodule

@@ hdl/tple_datapath.sv @@
// ----------------------------------------------------------------------------
// tple_datapath
// Cursor, page and count registers, tab remainder unit, configuration
// registers and the output register, all driven by the control word.
// ----------------------------------------------------------------------------
module tple_datapath #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_LINES   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wr_data,
    input  logic [7:0]           s_text_byte,
    input  tple_pkg::ctrl_word_t cw,
    input  logic                 step_go,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [1:0]           m_op_kind,
    output logic [7:0]           m_out_char,
    output logic [5:0]           m_cursor_row,
    output logic [6:0]           m_cursor_col,
    output logic [15:0]          m_bytes_used,
    output logic                 m_last_of_run,
    output tple_pkg::dp_status_t status
);
    import tple_pkg::*;

    // configuration
    logic [6:0] cols_cfg_reg;
    logic [5:0] lines_cfg_reg;
    logic [7:0] tab_cfg_reg;

    logic [7:0] cols_eff;
    logic [5:0] lines_eff;
    logic [5:0] text_rows;
    logic [4:0] tab_eff;

    // working state; row and column carry one spare bit within an item
    logic [7:0]  byte_reg,  byte_next;
    logic [6:0]  row_reg,   row_next;
    logic [7:0]  col_reg,   col_next;
    logic        open_reg,  open_next;
    logic [15:0] count_reg, count_next;
    logic [3:0]  rem_reg,   rem_next;
    logic [2:0]  bit_reg,   bit_next;
    logic [4:0]  spc_reg,   spc_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg,    kind_next;
    logic [7:0]  char_reg,    char_next;
    logic [5:0]  orow_reg,    orow_next;
    logic [6:0]  ocol_reg,    ocol_next;
    logic [15:0] used_reg,    used_next;
    logic        last_reg,    last_next;

    logic [6:0]  col_m1;
    logic [4:0]  mod_trial;
    logic        last_val;
    logic        do_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg  <= COLUMNS_RESET;
            lines_cfg_reg <= LINES_RESET;
            tab_cfg_reg   <= TAB_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCREEN_COLUMNS: cols_cfg_reg  <= cfg_wr_data[6:0];
                REG_SCREEN_LINES:   lines_cfg_reg <= cfg_wr_data[5:0];
                REG_TAB_WIDTH:      tab_cfg_reg   <= cfg_wr_data;
                default:            ;
            endcase
        end
    end

    // clamp the geometry
    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_eff = 8'd1;
        end else if ({1'b0, cols_cfg_reg} > 8'(MAX_COLUMNS)) begin
            cols_eff = 8'(MAX_COLUMNS);
        end else begin
            cols_eff = {1'b0, cols_cfg_reg};
        end

        if (lines_cfg_reg == '0) begin
            lines_eff = 6'd1;
        end else if ({1'b0, lines_cfg_reg} > 7'(MAX_LINES)) begin
            lines_eff = 6'(MAX_LINES);
        end else begin
            lines_eff = lines_cfg_reg;
        end
        text_rows = (lines_eff > 6'd1) ? lines_eff - 6'd1 : lines_eff;

        if (tab_cfg_reg == '0) begin
            tab_eff = TAB_DEFAULT;
        end else if (tab_cfg_reg > {3'b000, TAB_MAX}) begin
            tab_eff = TAB_MAX;
        end else begin
            tab_eff = tab_cfg_reg[4:0];
        end
    end

    // restoring remainder of (col - 1) by the tab width, one bit a step
    assign col_m1    = col_reg[6:0] - 7'd1;
    assign mod_trial = {rem_reg, col_m1[bit_reg]};

    always_comb begin
        byte_next  = byte_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        open_next  = open_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        spc_next   = spc_reg;
        if (step_go) begin
            case (cw.action)
                ACT_LOAD: begin
                    byte_next = s_text_byte;
                    row_next  = {1'b0, row_reg[5:0]};
                    col_next  = {1'b0, col_reg[6:0]};
                    rem_next  = '0;
                    bit_next  = 3'd6;
                end
                ACT_OPEN: begin
                    open_next  = 1'b1;
                    row_next   = 7'd1;
                    col_next   = 8'd1;
                    count_next = '0;
                end
                ACT_COUNT: begin
                    if (byte_reg != CHR_NUL && count_reg != COUNT_MAX) begin
                        count_next = count_reg + 16'd1;
                    end
                end
                ACT_CLOSE:   open_next = 1'b0;
                ACT_WRAP: begin
                    row_next = row_reg + 7'd1;
                    col_next = 8'd1;
                end
                ACT_HOME: begin
                    row_next = 7'd1;
                    col_next = 8'd1;
                end
                ACT_COL_DEC: col_next = col_reg - 8'd1;
                ACT_COL_INC: col_next = col_reg + 8'd1;
                ACT_MOD_STEP: begin
                    if (mod_trial >= tab_eff) begin
                        rem_next = 4'(mod_trial - tab_eff);
                    end else begin
                        rem_next = mod_trial[3:0];
                    end
                    bit_next = bit_reg - 3'd1;
                end
                ACT_SPC_INIT: spc_next = tab_eff - {1'b0, rem_reg};
                ACT_TAB_PUT: begin
                    col_next = col_reg + 8'd1;
                    spc_next = spc_reg - 5'd1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cw.last_sel)
            LAST_YES:  last_val = 1'b1;
            LAST_OPEN: last_val = (byte_reg == CHR_CR) || (byte_reg == CHR_BS);
            LAST_TAB:  last_val = (spc_reg == 5'd1);
            default:   last_val = 1'b0;
        endcase
    end

    assign do_emit = step_go && cw.emit;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        char_next    = char_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        used_next    = used_reg;
        last_next    = last_reg;
        if (do_emit) begin
            m_valid_next = 1'b1;
            kind_next    = cw.op_kind;
            last_next    = last_val;
            case (cw.char_sel)
                CH_BYTE:  char_next = byte_reg;
                CH_CR:    char_next = CHR_CR;
                CH_LF:    char_next = CHR_LF;
                CH_BS:    char_next = CHR_BS;
                CH_SPACE: char_next = CHR_SPACE;
                default:  char_next = CHR_NUL;
            endcase
            orow_next = (cw.op_kind == OP_BLANK_REST) ? row_reg[5:0] : '0;
            ocol_next = (cw.op_kind == OP_BLANK_REST) ? col_reg[6:0] : '0;
            used_next = (cw.op_kind == OP_PAGE_END) ? count_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= 7'd1;
            col_reg     <= 8'd1;
            open_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            open_reg    <= open_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        rem_reg  <= rem_next;
        bit_reg  <= bit_next;
        spc_reg  <= spc_next;
        kind_reg <= kind_next;
        char_reg <= char_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
        used_reg <= used_next;
        last_reg <= last_next;
    end

    always_comb begin
        status.page_open = open_reg;
        status.col_ovf   = col_reg > cols_eff;
        status.row_ovf   = row_reg > {1'b0, text_rows};
        status.col_gt1   = col_reg > 8'd1;
        status.bit_zero  = (bit_reg == '0);
        status.spc_one   = (spc_reg == 5'd1);
        status.out_busy  = m_valid_reg && !m_ready;
        unique case (byte_reg)
            CHR_NUL: status.byte_class = CLS_NUL;
            CHR_BS:  status.byte_class = CLS_BS;
            CHR_FF:  status.byte_class = CLS_FF;
            CHR_CR:  status.byte_class = CLS_CR;
            CHR_TAB: status.byte_class = CLS_TAB;
            CHR_LF:  status.byte_class = CLS_LF;
            default: status.byte_class = CLS_PRINT;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_op_kind     = kind_reg;
    assign m_out_char    = char_reg;
    assign m_cursor_row  = orow_reg;
    assign m_cursor_col  = ocol_reg;
    assign m_bytes_used  = used_reg;
    assign m_last_of_run = last_reg;

endmodule

@@ bench/console_op_checker.sv @@
// ----------------------------------------------------------------------------
// console_op_checker
// Watches the text and console channels of the page layout engine. It keeps
// its own copy of the geometry registers and of the cursor, works out the
// console operations that each accepted text word must cause, and compares
// every accepted operation field by field against the oldest one outstanding.
// ----------------------------------------------------------------------------
module console_op_checker #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_LINES   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_op_kind,
    input  logic [7:0]  m_out_char,
    input  logic [5:0]  m_cursor_row,
    input  logic [6:0]  m_cursor_col,
    input  logic [15:0] m_bytes_used,
    input  logic        m_last_of_run,
    input  logic        run_done,
    output int          fail_count,
    output int          pending
);
    import tple_pkg::*;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  ch;
        logic [5:0]  row;
        logic [6:0]  col;
        logic [15:0] used;
        logic        last_op;
    } console_op_t;

    console_op_t console_ops[$];

    logic [6:0] scr_cols;
    logic [5:0] scr_lines;
    logic [7:0] tab_span;

    int row_at;
    int col_at;
    bit page_live;
    int page_bytes;
    bit leftover_checked;

    task automatic note_op(input op_kind_t kind, input logic [7:0] ch, input int r,
                           input int c, input int cnt);
        console_op_t e;
        e.kind    = kind;
        e.ch      = ch;
        e.row     = r[5:0];
        e.col     = c[6:0];
        e.used    = cnt[15:0];
        e.last_op = 1'b0;
        console_ops.push_back(e);
    endtask

    // CR LF unless the new row falls below the view
    task automatic next_line(input int text_rows, output bit full);
        row_at++;
        col_at = 1;
        full = (row_at > text_rows);
        if (!full) begin
            note_op(OP_PUT_CHAR, CHR_CR, 0, 0, 0);
            note_op(OP_PUT_CHAR, CHR_LF, 0, 0, 0);
        end
    endtask

    task automatic lay_out_byte(input logic [7:0] b);
        int cols;
        int lines;
        int tabw;
        int text_rows;
        int spaces;
        int base;
        bit full;
        console_op_t e;

        cols  = int'(scr_cols);
        lines = int'(scr_lines);
        tabw  = int'(tab_span);
        if (cols < 1) cols = 1;
        if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
        if (lines < 1) lines = 1;
        if (lines > MAX_LINES) lines = MAX_LINES;
        text_rows = (lines > 1) ? lines - 1 : lines;
        if (tabw < 1) tabw = int'(TAB_DEFAULT);
        if (tabw > int'(TAB_MAX)) tabw = int'(TAB_MAX);

        full = 1'b0;
        base = console_ops.size();

        if (!page_live) begin
            note_op(OP_CLEAR_HOME, 8'h00, 0, 0, 0);
            page_live  = 1'b1;
            row_at     = 1;
            col_at     = 1;
            page_bytes = 0;
        end

        if (b == CHR_NUL) begin
            note_op(OP_BLANK_REST, 8'h00, row_at, col_at, 0);
            note_op(OP_PAGE_END, 8'h00, 0, 0, page_bytes);
            page_live = 1'b0;
        end else begin
            if (page_bytes < COUNT_MAX) page_bytes++;
            case (b)
                CHR_BS: begin
                    if (col_at > 1) begin
                        note_op(OP_PUT_CHAR, CHR_BS, 0, 0, 0);
                        note_op(OP_PUT_CHAR, CHR_SPACE, 0, 0, 0);
                        note_op(OP_PUT_CHAR, CHR_BS, 0, 0, 0);
                        col_at--;
                    end
                end
                CHR_FF: begin
                    note_op(OP_CLEAR_HOME, 8'h00, 0, 0, 0);
                    row_at = 1;
                    col_at = 1;
                end
                CHR_CR: begin
                end
                CHR_TAB: begin
                    spaces = tabw - ((col_at - 1) % tabw);
                    while (spaces > 0 && !full) begin
                        spaces--;
                        if (col_at > cols) next_line(text_rows, full);
                        if (!full) begin
                            note_op(OP_PUT_CHAR, CHR_SPACE, 0, 0, 0);
                            col_at++;
                        end
                    end
                end
                CHR_LF: next_line(text_rows, full);
                default: begin
                    if (col_at > cols) next_line(text_rows, full);
                    if (!full) begin
                        note_op(OP_PUT_CHAR, b, 0, 0, 0);
                        col_at++;
                    end
                end
            endcase
            if (full) begin
                note_op(OP_PAGE_END, 8'h00, 0, 0, page_bytes);
                page_live = 1'b0;
            end
        end

        row_at &= 32'h3F;
        col_at &= 32'h7F;

        // flag the final operation of this word
        if (console_ops.size() > base) begin
            e = console_ops.pop_back();
            e.last_op = 1'b1;
            console_ops.push_back(e);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        console_op_t e;
        if (!aresetn) begin
            scr_cols         = COLUMNS_RESET;
            scr_lines        = LINES_RESET;
            tab_span         = TAB_RESET;
            row_at           = 1;
            col_at           = 1;
            page_live        = 1'b0;
            page_bytes       = 0;
            leftover_checked = 1'b0;
            console_ops.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SCREEN_COLUMNS: scr_cols  = cfg_wr_data[6:0];
                    REG_SCREEN_LINES:   scr_lines = cfg_wr_data[5:0];
                    REG_TAB_WIDTH:      tab_span  = cfg_wr_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) lay_out_byte(s_text_byte);

            if (m_valid && m_ready) begin
                if (console_ops.size() == 0) begin
                    $error("console word op_kind %0d with nothing outstanding", m_op_kind);
                    fail_count++;
                end else begin
                    e = console_ops.pop_front();
                    check_field("op_kind", 16'(e.kind), 16'(m_op_kind));
                    check_field("out_char", 16'(e.ch), 16'(m_out_char));
                    check_field("cursor_row", 16'(e.row), 16'(m_cursor_row));
                    check_field("cursor_col", 16'(e.col), 16'(m_cursor_col));
                    check_field("bytes_used", e.used, m_bytes_used);
                    check_field("last_of_run", 16'(e.last_op), 16'(m_last_of_run));
                end
            end

            if (run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (console_ops.size() != 0) begin
                    $error("%0d console words never arrived", console_ops.size());
                    fail_count++;
                end
            end
        end
        pending <= console_ops.size();
    end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Feeds text pages to the page layout engine: a short opening sequence of
// edge bytes and control codes, then random text under a series of screen
// geometries, with random gaps and stalls on both channels. The checker
// beside the engine predicts and compares; this module drives stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import tple_pkg::*;

    localparam int MAX_COLUMNS     = 80;
    localparam int MAX_LINES       = 32;
    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 44;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = REG_SCREEN_COLUMNS;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_op_kind;
    logic [7:0]  m_out_char;
    logic [5:0]  m_cursor_row;
    logic [6:0]  m_cursor_col;
    logic [15:0] m_bytes_used;
    logic        m_last_of_run;
    logic        run_done    = 1'b0;

    int fail_count;
    int pending;

    bit tx_gapless = 1'b0;
    bit rx_gapless = 1'b0;
    bit hold_req   = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    text_page_layout_engine #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_LINES  (MAX_LINES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_op_kind    (m_op_kind),
        .m_out_char   (m_out_char),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_bytes_used (m_bytes_used),
        .m_last_of_run(m_last_of_run)
    );

    console_op_checker #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_LINES  (MAX_LINES)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_op_kind    (m_op_kind),
        .m_out_char   (m_out_char),
        .m_cursor_row (m_cursor_row),
        .m_cursor_col (m_cursor_col),
        .m_bytes_used (m_bytes_used),
        .m_last_of_run(m_last_of_run),
        .run_done     (run_done),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // valid drops only after acceptance, and only when a gap follows
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] lines,
                                input logic [7:0] tabw);
        write_reg(REG_SCREEN_COLUMNS, cols);
        write_reg(REG_SCREEN_LINES, lines);
        write_reg(REG_TAB_WIDTH, tabw);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly text, with control codes often enough to close pages
    function automatic logic [7:0] pick_text_byte();
        int roll;
        logic [7:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 55)      v = 8'($urandom_range(32, 255));
        else if (roll < 65) v = CHR_LF;
        else if (roll < 73) v = CHR_TAB;
        else if (roll < 79) v = CHR_BS;
        else if (roll < 83) v = CHR_FF;
        else if (roll < 87) v = CHR_CR;
        else if (roll < 92) v = CHR_NUL;
        else                v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = rx_gapless ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : text_source
        logic [7:0] opening [0:16];
        int mode;

        // NUL with no page open, CR opening a page, CR inside it, edge bytes, erase,
        // tab, erase, newline, erase at column one, form feed, two bytes, NUL closing
        opening = '{CHR_NUL, CHR_CR, CHR_CR, 8'h41, 8'hFF, 8'h01, 8'h7F, 8'h80,
                    CHR_BS, CHR_TAB, CHR_BS, CHR_LF, CHR_BS, CHR_FF, 8'h55, 8'hAA,
                    CHR_NUL};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i]) send_byte(opening[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: ;
                1: set_geometry(8'd0, 8'd0, 8'd0);
                2: set_geometry(8'd127, 8'd63, 8'd255);
                3: set_geometry(8'd1, 8'd2, 8'd1);
                4: set_geometry(8'd80, 8'd32, 8'd16);
                5: set_geometry(8'd7, 8'd3, 8'd17);
                default: set_geometry(8'($urandom_range(0, 127)),
                                      8'($urandom_range(0, 63)),
                                      8'($urandom_range(0, 255)));
            endcase
            mode = (ph == 1) ? 3 : $urandom_range(0, 3);
            tx_gapless = mode[0];
            rx_gapless = mode[1];
            if (ph == 3) hold_req = 1'b1;
            repeat (WORDS_PER_PHASE) send_byte(pick_text_byte());
            drain_results();
        end

        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/tple_pkg.sv
hdl/tple_ucode_rom.sv
hdl/tple_sequencer.sv
hdl/tple_datapath.sv
hdl/text_page_layout_engine.sv
bench/console_op_checker.sv
bench/testbench.sv
